// ----- src/pipc_pkg.sv -----
// Package for the point-in-primitive classifier: shape codes, location codes,
// register indexes and the limb width of the pipelined multiplier. No dependencies.
`default_nettype none

package pipc_pkg;

  // Limb width of the partial-product multiplier
  localparam int LIMB_W = 32;

  // Width of the configuration register index and data
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 31;

  typedef enum logic [2:0] {
    SHAPE_BOX      = 3'd0,
    SHAPE_CYLINDER = 3'd1,
    SHAPE_PYRAMID  = 3'd2,
    SHAPE_CONE     = 3'd3,
    SHAPE_SPHERE   = 3'd4
  } shape_e;

  typedef enum logic [1:0] {
    LOC_OUTSIDE = 2'd0,
    LOC_BORDER  = 2'd1,
    LOC_INSIDE  = 2'd2
  } loc_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_KIND = 3'd0,
    REG_DIM_A      = 3'd1,
    REG_DIM_B      = 3'd2,
    REG_DIM_C      = 3'd3,
    REG_TOLERANCE  = 3'd4
  } cfg_reg_e;

  // Cone flags that travel alongside the wide products
  typedef struct packed {
    logic valid;
    logic early_out;
    logic in_depth;
    logic inner_ok;
  } cone_flags_t;

endpackage : pipc_pkg

`default_nettype wire

// ----- src/pipc_mul.sv -----
// Two-stage unsigned multiplier built from limb-sized partial products.
// Depends on pipc_pkg for the limb width.
`default_nettype none

module pipc_mul #(
  parameter int WA = 64,
  parameter int WB = 64
) (
  input  wire logic             clk_i,
  input  wire logic [WA-1:0]    a_i,
  input  wire logic [WB-1:0]    b_i,
  output logic      [WA+WB-1:0] p_o
);
  import pipc_pkg::*;

  localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int WS = (NA + NB) * LIMB_W;

  logic [NA*LIMB_W-1:0] a_pad;
  logic [NB*LIMB_W-1:0] b_pad;
  logic [2*LIMB_W-1:0]  pp_q [NA*NB];
  logic [WS-1:0]        acc;
  logic [WA+WB-1:0]     p_q;

  assign a_pad = (NA*LIMB_W)'(a_i);
  assign b_pad = (NB*LIMB_W)'(b_i);

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                      * (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  // stage 2: weighted sum
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (WS'(pp_q[i*NB+j]) << ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= acc[WA+WB-1:0];
  end

  assign p_o = p_q;

endmodule : pipc_mul

`default_nettype wire

// ----- src/point_in_primitive_classifier_top.sv -----
// Top level of the point-in-primitive classifier: configuration registers,
// six-stage classification pipeline. Depends on pipc_pkg and pipc_mul.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | start_i, busy_o, point_x/y/z_i          | taken when start_i & !busy_o
//  result   | done_o, where_is_o                      | one-cycle strobe, no stall
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,  | write when valid & ready
//           | cfg_data_i                              |
//
// One request per cycle; busy_o stays low. The pipeline depth is set by the
// cone path: magnitudes, squares and products, sums and compares, then the
// two-stage wide multiplier and a final compare. Reset clears the valid chain
// and the configuration registers to zero; the datapath registers are not reset.
// Results cannot be stalled, so the pipeline advances on every clock.
`default_nettype none

module point_in_primitive_classifier_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]    point_z_i,
  output logic                                  done_o,
  output logic             [1:0]                where_is_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pipc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pipc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pipc_pkg::*;

  localparam int MW   = COORD_WIDTH;                    // magnitude width
  localparam int CW   = (MW + 2 > 35) ? MW + 2 : 35;    // narrow compares
  localparam int PP   = (MW + 32 > 63) ? MW + 32 : 63;  // pyramid products
  localparam int PS   = PP + 2;                         // pyramid sums
  localparam int SQ   = 2 * MW + 1;                     // x^2 + y^2
  localparam int SW   = (2 * MW + 2 > 64) ? 2 * MW + 3 : 65; // sphere sums
  localparam int BW   = (MW + 31 > 62) ? MW + 32 : 63;  // cone bounds
  localparam int HW   = 2 * DIM_W;                      // h*h
  localparam int HSW  = HW + SQ;
  localparam int CMPW = (HSW > 2 * BW) ? HSW : 2 * BW;

  // ---------------- configuration registers ----------------
  logic [2:0]       kind_q;
  logic [DIM_W-1:0] dim_a_q, dim_b_q, dim_c_q, tol_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= '0;
      dim_a_q <= '0;
      dim_b_q <= '0;
      dim_c_q <= '0;
      tol_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHAPE_KIND: kind_q  <= cfg_data_i[2:0];
        REG_DIM_A:      dim_a_q <= cfg_data_i[DIM_W-1:0];
        REG_DIM_B:      dim_b_q <= cfg_data_i[DIM_W-1:0];
        REG_DIM_C:      dim_c_q <= cfg_data_i[DIM_W-1:0];
        REG_TOLERANCE:  tol_q   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- valid chain ----------------
  logic [5:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[4:0], start_i};
  end

  // ---------------- stage 1: magnitudes ----------------
  logic [MW-1:0] ax1_q, ay1_q, az1_q;
  logic          nz1_q;

  always_ff @(posedge clk_i) begin
    ax1_q <= point_x_i[MW-1] ? (~point_x_i + 1'b1) : point_x_i;
    ay1_q <= point_y_i[MW-1] ? (~point_y_i + 1'b1) : point_y_i;
    az1_q <= point_z_i[MW-1] ? (~point_z_i + 1'b1) : point_z_i;
    nz1_q <= point_z_i[MW-1];
  end

  // ---------------- stage 2: products and narrow flags ----------------
  logic [CW-1:0] t_w, a_w, b_w, c_w, axw, ayw, azw;
  assign t_w = CW'(tol_q);
  assign a_w = CW'(dim_a_q);
  assign b_w = CW'(dim_b_q);
  assign c_w = CW'(dim_c_q);
  assign axw = CW'(ax1_q);
  assign ayw = CW'(ay1_q);
  assign azw = CW'(az1_q);

  // w = -z is non-negative when z is negative or zero
  logic wnn1;
  assign wnn1 = nz1_q || (az1_q == '0);

  function automatic logic [1:0] box_axis(input logic [CW-1:0] m, input logic [CW-1:0] e,
                                          input logic [CW-1:0] t);
    logic [CW-1:0] m2, diff;
    logic          o, b;
    m2   = m << 1;
    o    = m2 > (e + t);
    diff = (m2 > e) ? (m2 - e) : (e - m2);
    b    = diff < (t << 1);
    return {o, b};
  endfunction

  logic [1:0] bx, by, bz;
  logic [1:0] box_res2_d;
  always_comb begin
    bx = box_axis(axw, a_w, t_w);
    by = box_axis(ayw, b_w, t_w);
    bz = box_axis(azw, c_w, t_w);
    if (bx[1] || by[1] || bz[1])      box_res2_d = LOC_OUTSIDE;
    else if (bx[0] || by[0] || bz[0]) box_res2_d = LOC_BORDER;
    else                              box_res2_d = LOC_INSIDE;
  end

  logic [2*MW-1:0] sx2_q, sy2_q, sz2_q;
  logic [1:0]      box_res2_q;
  // cylinder
  logic            cyl_out2_q, cyl_in2_q, cyl_rgt2_q;
  logic [63:0]     rpt2_q, rmt2_q;
  // pyramid
  logic            pyr_out2_q, pyr_inz2_q, wnn2_q;
  logic [PP-1:0]   lx2_q, ly2_q, wex2_q, wey2_q, tth2_q;
  // cone
  logic            cone_out2_q, cone_inz2_q;
  logic [BW-1:0]   wr2_q, th2_q;
  logic [HW-1:0]   hh2_q;
  // sphere
  logic [HW-1:0]   big2_q;

  logic [31:0] rpt, rmt;
  assign rpt = 32'(dim_a_q) + 32'(tol_q);
  assign rmt = 32'(dim_a_q) - 32'(tol_q);

  always_ff @(posedge clk_i) begin
    sx2_q      <= (2*MW)'(ax1_q) * (2*MW)'(ax1_q);
    sy2_q      <= (2*MW)'(ay1_q) * (2*MW)'(ay1_q);
    sz2_q      <= (2*MW)'(az1_q) * (2*MW)'(az1_q);
    box_res2_q <= box_res2_d;

    cyl_out2_q <= (azw << 1) > (b_w + (t_w << 1));
    cyl_in2_q  <= b_w > ((azw << 1) + (t_w << 1));
    cyl_rgt2_q <= a_w > t_w;
    rpt2_q     <= 64'(rpt) * 64'(rpt);
    rmt2_q     <= 64'(rmt) * 64'(rmt);

    pyr_out2_q <= (c_w == '0) || (!nz1_q && azw > t_w) || (nz1_q && azw > c_w + t_w);
    pyr_inz2_q <= nz1_q && azw > t_w && (azw + t_w) < c_w;
    wnn2_q     <= wnn1;
    lx2_q      <= PP'(c_w << 1) * PP'(ax1_q);
    ly2_q      <= PP'(c_w << 1) * PP'(ay1_q);
    wex2_q     <= PP'(az1_q) * PP'(dim_a_q);
    wey2_q     <= PP'(az1_q) * PP'(dim_b_q);
    tth2_q     <= PP'(t_w << 1) * PP'(dim_c_q);

    cone_out2_q <= (b_w == '0) || (!nz1_q && azw > t_w) || (nz1_q && azw > b_w + t_w);
    cone_inz2_q <= nz1_q && azw > t_w && (azw + t_w) < b_w;
    wr2_q       <= BW'(az1_q) * BW'(dim_a_q);
    th2_q       <= BW'(tol_q) * BW'(dim_b_q);
    hh2_q       <= HW'(dim_b_q) * HW'(dim_b_q);

    big2_q      <= HW'(dim_a_q) * HW'(dim_a_q);
  end

  // ---------------- stage 3: sums and compares ----------------
  logic [SQ-1:0] s3_d;
  logic [SW-1:0] r2, bigw, ttw, sw;
  logic [1:0]    cyl_res, sph_res, pyr_res, res3_d;
  logic          pox, poy, pix, piy;
  logic [PS-1:0] lxs, lys, wexs, weys, tths;
  logic          cneg, binok;
  logic [BW-1:0] b3_d, bin3_d;

  always_comb begin
    s3_d = SQ'(sx2_q) + SQ'(sy2_q);
    sw   = SW'(s3_d);
    r2   = sw + SW'(sz2_q);
    bigw = SW'(big2_q);
    ttw  = SW'(tol_q) << FRAC_BITS;

    // cylinder
    if (cyl_out2_q || sw > SW'(rpt2_q))                    cyl_res = LOC_OUTSIDE;
    else if (cyl_in2_q && cyl_rgt2_q && sw < SW'(rmt2_q))  cyl_res = LOC_INSIDE;
    else                                                   cyl_res = LOC_BORDER;

    // sphere
    if (r2 > bigw + ttw)      sph_res = LOC_OUTSIDE;
    else if (bigw > r2 + ttw) sph_res = LOC_INSIDE;
    else                      sph_res = LOC_BORDER;

    // pyramid: 2h|x| and 2h|y| against w*edge + 2th
    lxs  = PS'(lx2_q);
    lys  = PS'(ly2_q);
    wexs = PS'(wex2_q);
    weys = PS'(wey2_q);
    tths = PS'(tth2_q);
    pox  = wnn2_q ? (lxs > wexs + tths) : (lxs + wexs > tths);
    poy  = wnn2_q ? (lys > weys + tths) : (lys + weys > tths);
    pix  = lxs + tths < wexs;
    piy  = lys + tths < weys;
    if (pyr_out2_q || pox || poy)    pyr_res = LOC_OUTSIDE;
    else if (pyr_inz2_q && pix && piy) pyr_res = LOC_INSIDE;
    else                             pyr_res = LOC_BORDER;

    // cone lateral bounds
    binok  = wr2_q > th2_q;
    bin3_d = wr2_q - th2_q;
    cneg   = !wnn2_q && binok;
    b3_d   = wnn2_q ? (wr2_q + th2_q) : (th2_q - wr2_q);

    case (kind_q)
      SHAPE_BOX:      res3_d = box_res2_q;
      SHAPE_CYLINDER: res3_d = cyl_res;
      SHAPE_PYRAMID:  res3_d = pyr_res;
      SHAPE_SPHERE:   res3_d = sph_res;
      default:        res3_d = LOC_OUTSIDE;
    endcase
  end

  logic [SQ-1:0] s3_q;
  logic [BW-1:0] b3_q, bin3_q;
  logic [HW-1:0] hh3_q;
  logic [1:0]    res3_q, res4_q, res5_q;
  cone_flags_t   cf3_q, cf4_q, cf5_q;

  always_ff @(posedge clk_i) begin
    s3_q              <= s3_d;
    b3_q              <= b3_d;
    bin3_q            <= bin3_d;
    hh3_q             <= hh2_q;
    res3_q            <= res3_d;
    cf3_q.valid       <= kind_q == SHAPE_CONE;
    cf3_q.early_out   <= cone_out2_q || cneg;
    cf3_q.in_depth    <= cone_inz2_q;
    cf3_q.inner_ok    <= binok;
    res4_q            <= res3_q;
    res5_q            <= res4_q;
    cf4_q             <= cf3_q;
    cf5_q             <= cf4_q;
  end

  // ---------------- stages 4-5: wide products for the cone ----------------
  logic [HSW-1:0]  hs5;
  logic [2*BW-1:0] bb5, bi5;

  pipc_mul #(.WA(HW), .WB(SQ)) u_mul_hs (
    .clk_i (clk_i), .a_i (hh3_q), .b_i (s3_q), .p_o (hs5)
  );
  pipc_mul #(.WA(BW), .WB(BW)) u_mul_bb (
    .clk_i (clk_i), .a_i (b3_q), .b_i (b3_q), .p_o (bb5)
  );
  pipc_mul #(.WA(BW), .WB(BW)) u_mul_bi (
    .clk_i (clk_i), .a_i (bin3_q), .b_i (bin3_q), .p_o (bi5)
  );

  // ---------------- stage 6: cone decision and output ----------------
  logic [1:0] res6_d;
  logic [1:0] res6_q;

  always_comb begin
    if (!cf5_q.valid)                             res6_d = res5_q;
    else if (cf5_q.early_out)                     res6_d = LOC_OUTSIDE;
    else if (CMPW'(hs5) > CMPW'(bb5))             res6_d = LOC_OUTSIDE;
    else if (cf5_q.in_depth && cf5_q.inner_ok &&
             CMPW'(hs5) < CMPW'(bi5))             res6_d = LOC_INSIDE;
    else                                          res6_d = LOC_BORDER;
  end

  always_ff @(posedge clk_i) begin
    res6_q <= res6_d;
  end

  assign done_o     = vld_q[5];
  assign where_is_o = res6_q;

endmodule : point_in_primitive_classifier_top

`default_nettype wire
